// ===== rtl/assert_macros.svh =====
// Assertion macros for the cache RTL.
// Used at the end of the top level; needs clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked every clock outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Expression that must never be true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  `ASSERT_CLK(label, !(expr), msg)

`endif

// ===== rtl/lfu_pkg.sv =====
// Shared types and constants for the LFU cache with LRU tie-break.
// No dependencies.
package lfu_pkg;

  localparam int ENTRIES    = 16;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int OCC_W      = $clog2(ENTRIES + 1);
  localparam int COUNT_BITS = 16;
  localparam int KEY_W      = 32;
  localparam int VAL_W      = 32;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [OCC_W-1:0]      occ_t;
  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [KEY_W-1:0]      key_t;
  typedef logic [VAL_W-1:0]      val_t;

  localparam cnt_t COUNT_MAX = '1;
  localparam cnt_t COUNT_ONE = cnt_t'(1);
  localparam val_t VAL_MISS  = '1;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_TOUCH  = 2'd1,
    OP_INSERT = 2'd2
  } upd_op_t;

  typedef struct packed {
    logic valid;
    key_t key;
    val_t value;
    cnt_t count;
    idx_t rank;
  } entry_t;

  typedef struct packed {
    logic found;
    idx_t hit_idx;
    val_t hit_value;
    cnt_t hit_count;
    idx_t hit_rank;
    logic vic_any;
    idx_t vic_idx;
    cnt_t vic_count;
    idx_t vic_rank;
    logic free_any;
    idx_t free_idx;
  } scan_res_t;

  typedef struct packed {
    upd_op_t op;
    idx_t    slot;
    logic    wr_value;
    key_t    key;
    val_t    value;
    cnt_t    count;
    logic    evict;
    idx_t    vic_idx;
    idx_t    pivot;
  } upd_t;

endpackage

// ===== rtl/lfu_cache_lru_tiebreak.sv =====
// Top level: LFU key-value cache with LRU tie-break, sequencer and result register.
// Uses lfu_pkg, lfu_store, lfu_scan and assert_macros.svh.
//
//   port group  dir  contents
//   in_         in   word: tuser = mode, tdata = key, value
//   out_        out  word: tuser = hit, evicted; tdata = read_value
//   cfg_        in   capacity write
//
// Each word goes through the accept edge, the shared compare unit over all 16 slots
// (one slot per cycle), and the update step.
// The update cycle waits while the result register is still full.
// rst_n is synchronous, active low; the cache comes up empty, capacity 16.
module lfu_cache_lru_tiebreak import lfu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] key, [63:32] value
  input  logic        in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] read_value
  output logic [1:0]  out_tuser,  // [0] hit, [1] evicted
  input  logic        cfg_we,
  input  logic [4:0]  cfg_data
);

`include "assert_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t    state_r, state_nxt;
  idx_t      idx_r;
  occ_t      occ_r, cap_r, capc;
  logic      mode_r;
  key_t      key_r;
  val_t      value_r;
  logic      out_valid_r, hit_r, ev_r;
  val_t      rv_r;
  entry_t    rd_entry;
  scan_res_t sres;
  upd_t      upd;
  logic      accept, do_upd, full, evict, insert, touch;
  idx_t      ins_slot;
  cnt_t      bumped;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign capc      = (cap_r > occ_t'(ENTRIES)) ? occ_t'(ENTRIES) : cap_r;
  assign do_upd    = (state_r == S_UPD) && (!out_valid_r || out_tready);
  assign full      = occ_r >= capc;
  assign touch     = sres.found && (!mode_r || capc != '0);
  assign evict     = mode_r && capc != '0 && !sres.found && full && sres.vic_any;
  assign insert    = mode_r && capc != '0 && !sres.found && (evict || sres.free_any);
  assign ins_slot  = (evict && (!sres.free_any || sres.vic_idx < sres.free_idx)) ?
                     sres.vic_idx : sres.free_idx;
  assign bumped    = (sres.hit_count == COUNT_MAX) ? sres.hit_count
                                                   : sres.hit_count + COUNT_ONE;

  always_comb begin
    upd.op       = OP_NONE;
    upd.slot     = sres.hit_idx;
    upd.wr_value = mode_r;
    upd.key      = key_r;
    upd.value    = value_r;
    upd.count    = bumped;
    upd.evict    = evict;
    upd.vic_idx  = sres.vic_idx;
    upd.pivot    = sres.hit_rank;
    if (do_upd && touch) begin
      upd.op = OP_TOUCH;
    end else if (do_upd && insert) begin
      upd.op    = OP_INSERT;
      upd.slot  = ins_slot;
      upd.count = COUNT_ONE;
      upd.pivot = sres.vic_rank;
    end
  end

  lfu_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (idx_r),
    .rd_entry (rd_entry),
    .upd      (upd)
  );

  lfu_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .step  (state_r == S_SCAN),
    .idx   (idx_r),
    .ent   (rd_entry),
    .key   (key_r),
    .res   (sres)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_SCAN;
      S_SCAN: if (idx_r == idx_t'(ENTRIES - 1)) state_nxt = S_UPD;
      S_UPD:  if (do_upd) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      occ_r       <= '0;
      cap_r       <= occ_t'(ENTRIES);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) cap_r <= cfg_data;
      if (accept) idx_r <= '0;
      else if (state_r == S_SCAN) idx_r <= idx_r + idx_t'(1);
      if (do_upd && insert) occ_r <= evict ? occ_r : occ_r + occ_t'(1);
      if (do_upd) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= in_tuser;
      key_r   <= in_tdata[31:0];
      value_r <= in_tdata[63:32];
    end
    if (do_upd) begin
      hit_r <= sres.found;
      ev_r  <= evict;
      if (mode_r) rv_r <= '0;
      else rv_r <= sres.found ? sres.hit_value : VAL_MISS;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = rv_r;
  assign out_tuser  = {ev_r, hit_r};

  `ASSERT_NEVER(a_occ_range, occ_r > occ_t'(ENTRIES), "occupancy above entry count")
  `ASSERT_CLK(a_scan_start, accept |=> (state_r == S_SCAN && idx_r == '0), "scan not started")
  `ASSERT_CLK(a_occ_hold, (!do_upd) |=> $stable(occ_r), "occupancy moved outside update")
  `ASSERT_NEVER(a_evict_miss, out_tvalid && out_tuser[1] && out_tuser[0], "eviction on a hit")

endmodule

// ===== rtl/lfu_store.sv =====
// Entry storage: valid, key, value, use count and recency rank per slot.
// One read port at the scan index; update command from the sequencer. Uses lfu_pkg.
module lfu_store import lfu_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  idx_t   rd_idx,
  output entry_t rd_entry,
  input  upd_t   upd
);

  logic valid_r [ENTRIES];
  key_t key_r   [ENTRIES];
  val_t val_r   [ENTRIES];
  cnt_t cnt_r   [ENTRIES];
  idx_t rank_r  [ENTRIES];

  always_comb begin
    rd_entry.valid = valid_r[rd_idx];
    rd_entry.key   = key_r[rd_idx];
    rd_entry.value = val_r[rd_idx];
    rd_entry.count = cnt_r[rd_idx];
    rd_entry.rank  = rank_r[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) valid_r[i] <= 1'b0;
    end else begin
      case (upd.op)
        OP_TOUCH: begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (idx_t'(i) == upd.slot) begin
              rank_r[i] <= '0;
              cnt_r[i]  <= upd.count;
              if (upd.wr_value) val_r[i] <= upd.value;
            end else if (valid_r[i] && rank_r[i] < upd.pivot) begin
              rank_r[i] <= rank_r[i] + idx_t'(1);
            end
          end
        end
        OP_INSERT: begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (idx_t'(i) == upd.slot) begin
              valid_r[i] <= 1'b1;
              key_r[i]   <= upd.key;
              val_r[i]   <= upd.value;
              cnt_r[i]   <= upd.count;
              rank_r[i]  <= '0;
            end else if (upd.evict && idx_t'(i) == upd.vic_idx) begin
              valid_r[i] <= 1'b0;
            end else if (valid_r[i] && !(upd.evict && rank_r[i] > upd.pivot)) begin
              rank_r[i] <= rank_r[i] + idx_t'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/lfu_scan.sv =====
// Shared compare unit: one entry per cycle for key match, victim and free slot.
// Holds the running scan result. Uses lfu_pkg.
module lfu_scan import lfu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      step,
  input  idx_t      idx,
  input  entry_t    ent,
  input  key_t      key,
  output scan_res_t res
);

  scan_res_t res_r, res_nxt;
  logic      match, better, free;

  assign match  = ent.valid && ent.key == key;
  assign better = ent.valid && (!res_r.vic_any || ent.count < res_r.vic_count ||
                  (ent.count == res_r.vic_count && ent.rank > res_r.vic_rank));
  assign free   = !ent.valid && !res_r.free_any;

  always_comb begin
    res_nxt = res_r;
    if (start) begin
      res_nxt.found    = 1'b0;
      res_nxt.vic_any  = 1'b0;
      res_nxt.free_any = 1'b0;
    end else if (step) begin
      if (match && !res_r.found) begin
        res_nxt.found     = 1'b1;
        res_nxt.hit_idx   = idx;
        res_nxt.hit_value = ent.value;
        res_nxt.hit_count = ent.count;
        res_nxt.hit_rank  = ent.rank;
      end
      if (better) begin
        res_nxt.vic_any   = 1'b1;
        res_nxt.vic_idx   = idx;
        res_nxt.vic_count = ent.count;
        res_nxt.vic_rank  = ent.rank;
      end
      if (free) begin
        res_nxt.free_any = 1'b1;
        res_nxt.free_idx = idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.found    <= 1'b0;
      res_r.vic_any  <= 1'b0;
      res_r.free_any <= 1'b0;
    end else begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for lfu_cache_lru_tiebreak: directed and random get/put traffic.
// The block's results are checked against a behavioral cache model kept here.
// Depends on lfu_pkg and the RTL top level only.
module tb_top import lfu_pkg::*; ();

  localparam int DRAIN_CYCLES = 24;
  localparam int QUIET_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RAND_PHASES  = 9;
  localparam int PHASE_WORDS  = 100;
  localparam int HOT_READS    = 20;
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct {
    logic hit;
    val_t read_value;
    logic evicted;
  } cache_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // [31:0] key, [63:32] value
  logic        in_tuser;   // [0] mode
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] read_value
  logic [1:0]  out_tuser;  // [0] hit, [1] evicted
  logic        cfg_we;
  logic [4:0]  cfg_data;

  // cache model state
  logic       slot_valid [ENTRIES];
  key_t       slot_key   [ENTRIES];
  val_t       slot_value [ENTRIES];
  cnt_t       slot_count [ENTRIES];
  int         slot_rank  [ENTRIES];
  int         slot_occ;
  logic [4:0] cache_cap;

  cache_result_t pending_results[$];
  int   mismatch_cnt;
  int   quiet_cycles;
  bit   no_gaps;
  int   hold_req;
  int   hold_seen;
  int   hold_left;
  int   stall_left;
  key_t key_pool[$];

  lfu_cache_lru_tiebreak u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Move slot s to most recent.
  task automatic touch_slot(input int s);
    int i;
    for (i = 0; i < ENTRIES; i++) begin
      if (slot_valid[i] && i != s && slot_rank[i] < slot_rank[s]) slot_rank[i]++;
    end
    slot_rank[s] = 0;
  endtask

  task automatic bump_and_touch(input int s);
    if (slot_count[s] != COUNT_MAX) slot_count[s]++;
    touch_slot(s);
  endtask

  task automatic cache_access(input logic mode, input key_t k, input val_t v,
                              output cache_result_t res);
    int i;
    int s;
    int vic;
    int lim;
    int vr;
    s = -1;
    for (i = 0; i < ENTRIES; i++) begin
      if (s < 0 && slot_valid[i] && slot_key[i] == k) s = i;
    end
    lim = (cache_cap > ENTRIES) ? ENTRIES : int'(cache_cap);
    res.hit = (s >= 0);
    res.read_value = '0;
    res.evicted = 1'b0;
    if (mode == OP_GET) begin
      if (s >= 0) begin
        res.read_value = slot_value[s];
        bump_and_touch(s);
      end else begin
        res.read_value = VAL_MISS;
      end
    end else if (lim != 0) begin
      if (s >= 0) begin
        slot_value[s] = v;
        bump_and_touch(s);
      end else begin
        if (slot_occ >= lim) begin
          vic = -1;
          for (i = 0; i < ENTRIES; i++) begin
            if (slot_valid[i] && (vic < 0 || slot_count[i] < slot_count[vic] ||
                (slot_count[i] == slot_count[vic] && slot_rank[i] > slot_rank[vic])))
              vic = i;
          end
          if (vic >= 0) begin
            vr = slot_rank[vic];
            slot_valid[vic] = 1'b0;
            for (i = 0; i < ENTRIES; i++) begin
              if (slot_valid[i] && slot_rank[i] > vr) slot_rank[i]--;
            end
            slot_occ--;
            res.evicted = 1'b1;
          end
        end
        s = -1;
        for (i = 0; i < ENTRIES; i++) begin
          if (s < 0 && !slot_valid[i]) s = i;
        end
        if (s >= 0) begin
          for (i = 0; i < ENTRIES; i++) begin
            if (slot_valid[i]) slot_rank[i]++;
          end
          slot_valid[s] = 1'b1;
          slot_key[s]   = k;
          slot_value[s] = v;
          slot_count[s] = COUNT_ONE;
          slot_rank[s]  = 0;
          slot_occ++;
        end
      end
    end
  endtask

  // Offer one word; valid stays high on return so back-to-back words need no toggle.
  task automatic send_word(input logic mode, input key_t k, input val_t v);
    int gap;
    cache_result_t res;
    gap = idle_len();
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {v, k};
    do @(posedge clk); while (!in_tready);
    cache_access(mode, k, v, res);
    pending_results.push_back(res);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [4:0] cap);
    wait_idle();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= cap;
    @(negedge clk);
    cfg_we <= 1'b0;
    cache_cap = cap;
  endtask

  // A often-read entry outlives a newer, less used entry on eviction.
  task automatic test_count_priority();
    int n;
    no_gaps = 1;
    set_capacity(5'd2);
    send_word(OP_PUT, 32'h1357_9BDF, 32'h0000_00A5);
    for (n = 0; n < HOT_READS; n++) send_word(OP_GET, 32'h1357_9BDF, $urandom);
    send_word(OP_PUT, 32'h2468_ACE0, 32'h0000_005A);
    repeat (4) send_word(OP_GET, 32'h2468_ACE0, 32'h0);
    send_word(OP_PUT, 32'h0F0F_0F0F, 32'h1111_1111);
    send_word(OP_GET, 32'h1357_9BDF, 32'h0);
    send_word(OP_GET, 32'h2468_ACE0, 32'h0);
    no_gaps = 0;
  endtask

  task automatic test_basic_ops();
    set_capacity(5'd16);
    send_word(OP_GET, 32'h0000_0000, 32'h0000_0000);
    send_word(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(OP_GET, 32'h8000_0000, 32'h0000_0000);
    send_word(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send_word(OP_PUT, 32'h8000_0000, 32'hFFFF_FFFF);
    send_word(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    send_word(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_word(OP_GET, 32'hFFFF_FFFF, 32'h1234_5678);
  endtask

  // Zero capacity, clamping above the entry count, and capacity below occupancy.
  task automatic test_capacity_edges();
    set_capacity(5'd0);
    send_word(OP_PUT, 32'h7FFF_FFFF, 32'h0000_007B);
    send_word(OP_PUT, 32'h0000_1234, 32'h0000_0005);
    send_word(OP_GET, 32'h7FFF_FFFF, 32'h0);
    send_word(OP_GET, 32'h0000_1234, 32'h0);
    set_capacity(5'd31);
    send_word(OP_PUT, 32'h0000_55AA, 32'h0000_0001);
    set_capacity(5'd1);
    send_word(OP_PUT, 32'h0000_3C3C, 32'h0000_0002);
    send_word(OP_PUT, 32'h0000_3C3D, 32'h0000_0003);
    send_word(OP_GET, 32'h0000_3C3C, 32'h0);
    set_capacity(5'd17);
    send_word(OP_PUT, 32'h0000_0099, 32'h0000_0009);
    send_word(OP_GET, 32'h0000_0099, 32'h0);
  endtask

  task automatic test_random_traffic();
    logic [4:0] caps [RAND_PHASES];
    int ph;
    int n;
    int psize;
    key_t k;
    caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd3, 5'd8, 5'd17, 5'd2, 5'd0};
    caps[RAND_PHASES-1] = 5'($urandom_range(0, 31));
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      set_capacity(caps[ph]);
      no_gaps = ($urandom_range(0, 3) == 0);
      psize = ((caps[ph] > ENTRIES) ? ENTRIES : int'(caps[ph])) + 4;
      key_pool.delete();
      key_pool.push_back(32'h0000_0000);
      key_pool.push_back(32'hFFFF_FFFF);
      while (key_pool.size() < psize) key_pool.push_back($urandom);
      if (ph == 0) hold_req++;
      for (n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(0, 9) == 0) k = $urandom;
        else k = key_pool[$urandom_range(0, psize - 1)];
        send_word(1'($urandom_range(0, 1)), k, $urandom);
      end
    end
    no_gaps = 0;
  endtask

  // Result sink: random stalls plus a requested long hold-off.
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      stall_left = idle_len();
      out_tready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    cache_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word, got hit %0b read_value %h evicted %0b",
                 $time, out_tuser[0], out_tdata, out_tuser[1]);
        mismatch_cnt++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_tuser[0] !== exp_res.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, exp_res.hit, out_tuser[0]);
          mismatch_cnt++;
        end
        if (out_tdata !== exp_res.read_value) begin
          $display("%0t: read_value expected %h actual %h",
                   $time, exp_res.read_value, out_tdata);
          mismatch_cnt++;
        end
        if (out_tuser[1] !== exp_res.evicted) begin
          $display("%0t: evicted expected %0b actual %0b",
                   $time, exp_res.evicted, out_tuser[1]);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = 1'b0;
    out_tready   = 1'b0;
    cfg_we       = 1'b0;
    cfg_data     = '0;
    mismatch_cnt = 0;
    quiet_cycles = 0;
    no_gaps      = 0;
    hold_req     = 0;
    hold_seen    = 0;
    hold_left    = 0;
    stall_left   = 0;
    slot_occ     = 0;
    cache_cap    = 5'd16;
    for (int i = 0; i < ENTRIES; i++) begin
      slot_valid[i] = 1'b0;
      slot_key[i]   = '0;
      slot_value[i] = '0;
      slot_count[i] = '0;
      slot_rank[i]  = 0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_count_priority();
    test_basic_ops();
    test_capacity_edges();
    test_random_traffic();
    wait_idle();

    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
